[hdl/wlet_pkg.sv]
package wlet_pkg;

	localparam logic [2:0] CMD_ADD_ON  = 3'd0;
	localparam logic [2:0] CMD_ADD_OFF = 3'd1;
	localparam logic [2:0] CMD_REMOVE  = 3'd2;
	localparam logic [2:0] CMD_RAND    = 3'd3;
	localparam logic [2:0] CMD_TICK    = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ID   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [5:0] MAX_LIGHT = 6'd31;
	localparam logic [3:0] DAY_SUN = 4'd0;
	localparam logic [3:0] DAY_MON = 4'd1;
	localparam logic [3:0] DAY_FRI = 4'd5;
	localparam logic [3:0] DAY_SAT = 4'd6;
	localparam logic [3:0] DAY_EVERY   = 4'd7;
	localparam logic [3:0] DAY_WEEKDAY = 4'd8;
	localparam logic [3:0] DAY_WEEKEND = 4'd9;
	localparam logic signed [12:0] MIN_PER_DAY = 13'sd1440;

	typedef struct packed {
		logic [4:0]  light;
		logic        off;
		logic [3:0]  day;
		logic [10:0] minute;
	} entry_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_FIN
	} seq_t;

	function automatic logic day_match(input logic [3:0] code, input logic [3:0] today);
		logic m;
		m = (code == today) || (code == DAY_EVERY);
		if (code == DAY_WEEKDAY && today >= DAY_MON && today <= DAY_FRI) m = 1'b1;
		if (code == DAY_WEEKEND && (today == DAY_SUN || today == DAY_SAT)) m = 1'b1;
		return m;
	endfunction

endpackage

[hdl/weekly_light_event_table.sv]
// An accepted command turns the slot ring once past the head, then issues its final word;
//   a tick hit after the first stalls the ring only while the output is blocked.
// A new command is taken only after that final word is pushed, since one full turn of the
//   slot ring past the single head processing unit serves one command at a time.
// Reset: arst_n clears all slot used flags (table empty), sequencer and output valid;
//   slot contents are not reset and are never read while unused.
module weekly_light_event_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: command[2:0], light_id[8:3], day_code[12:9], minute[23:13],
	//          random_offset[29:24], zero [31:30]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: status[1:0], fire_light[6:2], fire_off[7]
	output logic [7:0]  m_tdata,
	// m_tuser: fire_valid
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CW-1:0] CNT_END = CW'(TABLE_DEPTH - 1);

	// Slot ring: cell 0 is the head, the processed head word re-enters at the tail,
	// so one full turn restores the index order.
	logic             c_used  [TABLE_DEPTH];
	wlet_pkg::entry_t c_entry [TABLE_DEPTH];
	logic             h_used_new;
	wlet_pkg::entry_t h_entry_new;
	logic             step;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			if (gi == TABLE_DEPTH - 1) begin : g_tail
				wlet_cell u_cell (
					.clk(clk), .arst_n(arst_n), .en(step),
					.d_used(h_used_new), .d_entry(h_entry_new),
					.used(c_used[gi]), .entry(c_entry[gi])
				);
			end else begin : g_mid
				wlet_cell u_cell (
					.clk(clk), .arst_n(arst_n), .en(step),
					.d_used(c_used[gi+1]), .d_entry(c_entry[gi+1]),
					.used(c_used[gi]), .entry(c_entry[gi])
				);
			end
		end
	endgenerate

	// command registers
	wlet_pkg::seq_t state_q, state_d;
	logic [2:0]         cmd_q;
	logic               bad_q;
	logic [4:0]         id_q;
	logic [3:0]         day_q;
	logic [10:0]        min_q;
	logic signed [5:0]  ofs_q;
	logic [CW-1:0]      cnt_q;
	logic               hit_q;    // add placed / remove freed / randomize matched
	logic               pend_q;   // a tick hit waits for the next one to know tlast
	logic [4:0]         pend_light_q;
	logic               pend_off_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic              out_fire_q;
	logic [4:0]        out_light_q;
	logic              out_off_q;
	logic              out_last_q;

	logic       out_free;
	logic       push;
	logic [1:0] push_status;
	logic       push_fire;
	logic [4:0] push_light;
	logic       push_off;
	logic       push_last;
	logic       hit_now;
	logic       due;
	logic       exact;
	logic signed [12:0] sum;
	logic [10:0] min_new;

	wlet_pkg::entry_t h;
	logic             h_used;
	assign h      = c_entry[0];
	assign h_used = c_used[0];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == wlet_pkg::SEQ_IDLE);

	// head processing unit
	always_comb begin
		exact = h_used && h.light == id_q && h.day == day_q && h.minute == min_q;
		due   = h_used && h.minute == min_q && wlet_pkg::day_match(h.day, day_q);
		sum   = $signed({2'b00, h.minute}) + 13'(ofs_q);
		if (sum < 13'sd0) begin
			sum = sum + wlet_pkg::MIN_PER_DAY;
		end else if (sum >= wlet_pkg::MIN_PER_DAY) begin
			sum = sum - wlet_pkg::MIN_PER_DAY;
		end
		min_new     = sum[10:0];
		h_used_new  = h_used;
		h_entry_new = h;
		hit_now     = 1'b0;
		if (!bad_q) begin
			case (cmd_q)
				wlet_pkg::CMD_ADD_ON, wlet_pkg::CMD_ADD_OFF: begin
					if (!h_used && !hit_q) begin
						h_used_new         = 1'b1;
						h_entry_new.light  = id_q;
						h_entry_new.off    = cmd_q[0];
						h_entry_new.day    = day_q;
						h_entry_new.minute = min_q;
						hit_now            = 1'b1;
					end
				end
				wlet_pkg::CMD_REMOVE: begin
					if (exact && !hit_q) begin
						h_used_new = 1'b0;
						hit_now    = 1'b1;
					end
				end
				wlet_pkg::CMD_RAND: begin
					if (exact) begin
						h_entry_new.minute = min_new;
						hit_now            = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// sequencer and output push
	always_comb begin
		state_d     = state_q;
		step        = 1'b0;
		push        = 1'b0;
		push_status = wlet_pkg::ST_OK;
		push_fire   = 1'b0;
		push_light  = pend_light_q;
		push_off    = pend_off_q;
		push_last   = 1'b1;
		case (state_q)
			wlet_pkg::SEQ_IDLE: begin
				if (s_tvalid) state_d = wlet_pkg::SEQ_SCAN;
			end
			wlet_pkg::SEQ_SCAN: begin
				if (cmd_q == wlet_pkg::CMD_TICK && due && pend_q) begin
					push      = out_free;
					push_fire = 1'b1;
					push_last = 1'b0;
					step      = out_free;
				end else begin
					step = 1'b1;
				end
				if (step && cnt_q == CNT_END) state_d = wlet_pkg::SEQ_FIN;
			end
			wlet_pkg::SEQ_FIN: begin
				push = out_free;
				if (cmd_q == wlet_pkg::CMD_TICK && pend_q) begin
					push_fire = 1'b1;
				end else if (bad_q) begin
					push_status = wlet_pkg::ST_BAD_ID;
				end else if (cmd_q == wlet_pkg::CMD_ADD_ON || cmd_q == wlet_pkg::CMD_ADD_OFF) begin
					push_status = hit_q ? wlet_pkg::ST_OK : wlet_pkg::ST_FULL;
				end else if (cmd_q == wlet_pkg::CMD_REMOVE || cmd_q == wlet_pkg::CMD_RAND) begin
					push_status = hit_q ? wlet_pkg::ST_OK : wlet_pkg::ST_NOTFOUND;
				end
				if (out_free) state_d = wlet_pkg::SEQ_IDLE;
			end
			default: state_d = wlet_pkg::SEQ_IDLE;
		endcase
		if (!push_fire) begin
			push_light = 5'd0;
			push_off   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wlet_pkg::SEQ_IDLE;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_tvalid && s_tready) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				pend_q <= 1'b0;
			end else if (step) begin
				cnt_q <= (cnt_q == CNT_END) ? '0 : cnt_q + 1'b1;
				if (hit_now) hit_q <= 1'b1;
				if (cmd_q == wlet_pkg::CMD_TICK && due) pend_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tdata[2:0];
			bad_q <= (s_tdata[2:0] <= wlet_pkg::CMD_RAND) && (s_tdata[8:3] > wlet_pkg::MAX_LIGHT);
			id_q  <= s_tdata[7:3];
			day_q <= s_tdata[12:9];
			min_q <= s_tdata[23:13];
			ofs_q <= s_tdata[29:24];
		end
		if (step && cmd_q == wlet_pkg::CMD_TICK && due) begin
			pend_light_q <= h.light;
			pend_off_q   <= h.off;
		end
		if (push) begin
			out_status_q <= push_status;
			out_fire_q   <= push_fire;
			out_light_q  <= push_light;
			out_off_q    <= push_off;
			out_last_q   <= push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_off_q, out_light_q, out_status_q};
	assign m_tuser  = out_fire_q;
	assign m_tlast  = out_last_q;

	// the ring is parked at its home position whenever no command runs
	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlet_pkg::SEQ_IDLE) |-> (cnt_q == '0))
		else $error("ring not at home while idle");

	// every command closes with a final word
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlet_pkg::SEQ_FIN && out_free) |=> (m_tvalid && m_tlast))
		else $error("command ended without final word");

	// the ring never moves outside a scan
	a_step_scan: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (state_q == wlet_pkg::SEQ_SCAN))
		else $error("ring shifted outside scan");

	// fire words always carry ok status
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[1:0] == wlet_pkg::ST_OK))
		else $error("fire word with error status");

endmodule

[hdl/wlet_cell.sv]
// one table slot; shifts toward the head when en is high
module wlet_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             d_used,
	input  wlet_pkg::entry_t d_entry,
	output logic             used,
	output wlet_pkg::entry_t entry
);

	logic             used_q;
	wlet_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (en) begin
			used_q <= d_used;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= d_entry;
		end
	end

	assign used  = used_q;
	assign entry = entry_q;

endmodule

[verif/tb_weekly_light_event_table.sv]
module tb_weekly_light_event_table;

	localparam int DEPTH = 64;
	localparam logic [2:0] CMD_NOP = 3'd5;
	localparam int LIMIT = 4000000;
	localparam int HOLD_CYCLES = 2000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	weekly_light_event_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	typedef struct packed {
		logic [1:0] status;
		logic       fire_valid;
		logic [4:0] fire_light;
		logic       fire_off;
		logic       last;
	} word_t;

	// pending command words and expected output words
	logic [31:0] cmd_q[$];
	word_t       expect_q[$];

	// predictor's own copy of the table
	logic             tbl_used[DEPTH] = '{default: 1'b0};
	wlet_pkg::entry_t tbl_ent[DEPTH]  = '{default: '0};

	int errors = 0;
	int cycles = 0;
	int send_idle = 0;   // percent of cycles the sender idles
	int recv_stall = 0;  // percent of cycles the receiver stalls

	// long receiver hold-off, counted in its own process
	event hold_go;
	logic hold_on = 1'b0;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	always begin
		@(hold_go);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	function automatic logic day_hits(logic [3:0] code, logic [3:0] today);
		if (code == today || code == wlet_pkg::DAY_EVERY) return 1'b1;
		if (code == wlet_pkg::DAY_WEEKDAY && today >= wlet_pkg::DAY_MON
				&& today <= wlet_pkg::DAY_FRI) return 1'b1;
		if (code == wlet_pkg::DAY_WEEKEND && (today == wlet_pkg::DAY_SUN
				|| today == wlet_pkg::DAY_SAT)) return 1'b1;
		return 1'b0;
	endfunction

	function automatic word_t status_word(logic [1:0] st);
		word_t w;
		w = '0;
		w.status = st;
		w.last = 1'b1;
		return w;
	endfunction

	// Applies one command to the table copy and queues the words it yields.
	task automatic schedule_predict(input logic [31:0] d);
		logic [2:0] cmd;
		logic [5:0] id;
		logic [3:0] day;
		logic [10:0] mn;
		int off, sum, n;
		logic hit;
		word_t w;
		cmd = d[2:0]; id = d[8:3]; day = d[12:9]; mn = d[23:13];
		off = $signed(d[29:24]);
		if (cmd <= wlet_pkg::CMD_RAND && id > wlet_pkg::MAX_LIGHT) begin
			expect_q.push_back(status_word(wlet_pkg::ST_BAD_ID));
		end else if (cmd == wlet_pkg::CMD_ADD_ON || cmd == wlet_pkg::CMD_ADD_OFF) begin
			hit = 1'b0;
			for (int i = 0; i < DEPTH && !hit; i++)
				if (!tbl_used[i]) begin
					tbl_used[i] = 1'b1;
					tbl_ent[i] = '{id[4:0], cmd[0], day, mn};
					hit = 1'b1;
				end
			expect_q.push_back(status_word(hit ? wlet_pkg::ST_OK : wlet_pkg::ST_FULL));
		end else if (cmd == wlet_pkg::CMD_REMOVE) begin
			hit = 1'b0;
			for (int i = 0; i < DEPTH && !hit; i++)
				if (tbl_used[i] && tbl_ent[i].light == id[4:0] && tbl_ent[i].day == day
						&& tbl_ent[i].minute == mn) begin
					tbl_used[i] = 1'b0;
					hit = 1'b1;
				end
			expect_q.push_back(status_word(hit ? wlet_pkg::ST_OK : wlet_pkg::ST_NOTFOUND));
		end else if (cmd == wlet_pkg::CMD_RAND) begin
			hit = 1'b0;
			for (int i = 0; i < DEPTH; i++)
				if (tbl_used[i] && tbl_ent[i].light == id[4:0] && tbl_ent[i].day == day
						&& tbl_ent[i].minute == mn) begin
					sum = int'(tbl_ent[i].minute) + off;
					if (sum < 0) sum += 1440;
					else if (sum >= 1440) sum -= 1440;
					tbl_ent[i].minute = sum[10:0];
					hit = 1'b1;
				end
			expect_q.push_back(status_word(hit ? wlet_pkg::ST_OK : wlet_pkg::ST_NOTFOUND));
		end else if (cmd == wlet_pkg::CMD_TICK) begin
			n = 0;
			for (int i = 0; i < DEPTH; i++)
				if (tbl_used[i] && tbl_ent[i].minute == mn && day_hits(tbl_ent[i].day, day)) begin
					w = '0;
					w.fire_valid = 1'b1;
					w.fire_light = tbl_ent[i].light;
					w.fire_off = tbl_ent[i].off;
					expect_q.push_back(w);
					n++;
				end
			if (n == 0) expect_q.push_back(status_word(wlet_pkg::ST_OK));
			else expect_q[$].last = 1'b1;
		end else begin
			expect_q.push_back(status_word(wlet_pkg::ST_OK));
		end
	endtask

	task automatic report(input string msg);
		errors++;
		$display("ERROR @%0d: %s", cycles, msg);
	endtask

	function automatic logic [31:0] pack_cmd(logic [2:0] c, logic [5:0] id, logic [3:0] day,
			logic [10:0] mn, logic [5:0] off);
		return {2'b00, off, mn, day, id, c};
	endfunction

	// Driver: presents queued words; predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				schedule_predict(s_tdata);
				void'(cmd_q.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				// head of the queue is always the next word to present
				if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata  <= cmd_q[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor / receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (m_tvalid && m_tready) begin
				word_t got, exp;
				got = '{m_tdata[1:0], m_tuser, m_tdata[6:2], m_tdata[7], m_tlast};
				if (expect_q.size() == 0) begin
					report($sformatf("unexpected word %h", got));
				end else begin
					exp = expect_q.pop_front();
					if (got.status != exp.status)
						report($sformatf("status %0d, want %0d", got.status, exp.status));
					if (got.fire_valid != exp.fire_valid)
						report($sformatf("fire_valid %0d, want %0d", got.fire_valid,
							exp.fire_valid));
					if (got.fire_light != exp.fire_light)
						report($sformatf("fire_light %0d, want %0d", got.fire_light,
							exp.fire_light));
					if (got.fire_off != exp.fire_off)
						report($sformatf("fire_off %0d, want %0d", got.fire_off, exp.fire_off));
					if (got.last != exp.last)
						report($sformatf("last %0d, want %0d", got.last, exp.last));
				end
			end
			if (hold_on) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Timeout watch
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Random command with content biased toward what is in the table.
	function automatic logic [31:0] rand_cmd();
		logic [2:0] c;
		logic [5:0] id;
		logic [3:0] day;
		logic [10:0] mn;
		logic [5:0] off;
		int pick;
		pick = $urandom_range(99);
		id = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
		day = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
		mn = ($urandom_range(19) == 0) ? 11'($urandom_range(2047))
			: 11'(700 + $urandom_range(5));
		off = 6'($urandom_range(63));
		if (pick < 35) c = ($urandom_range(1) == 0) ? wlet_pkg::CMD_ADD_ON
			: wlet_pkg::CMD_ADD_OFF;
		else if (pick < 55) c = wlet_pkg::CMD_REMOVE;
		else if (pick < 68) c = wlet_pkg::CMD_RAND;
		else if (pick < 96) c = wlet_pkg::CMD_TICK;
		else c = 3'($urandom_range(5, 7));
		// reuse a stored entry's key so remove/randomize/tick actually hit
		if (c != wlet_pkg::CMD_ADD_ON && c != wlet_pkg::CMD_ADD_OFF
				&& $urandom_range(3) != 0) begin
			int k;
			k = $urandom_range(DEPTH - 1);
			if (tbl_used[k]) begin
				id = {1'b0, tbl_ent[k].light};
				mn = tbl_ent[k].minute;
				day = tbl_ent[k].day;
				if (c == wlet_pkg::CMD_TICK && day == wlet_pkg::DAY_WEEKDAY)
					day = 4'($urandom_range(1, 5));
				else if (c == wlet_pkg::CMD_TICK && day == wlet_pkg::DAY_WEEKEND)
					day = wlet_pkg::DAY_SAT;
				else if (c == wlet_pkg::CMD_TICK && day == wlet_pkg::DAY_EVERY)
					day = 4'($urandom_range(15));
			end
		end
		return pack_cmd(c, id, day, mn, off);
	endfunction

	task automatic drain();
		while (cmd_q.size() > 0 || expect_q.size() > 0) @(posedge clk);
		repeat (3 * DEPTH) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bad ids, all commands, wraps, odd codes, day classes
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_ADD_ON, 6'd63, 4'd0, 11'd0, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_REMOVE, 6'd32, 4'd0, 11'd0, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_RAND, 6'd40, 4'd0, 11'd0, 6'd1));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_ADD_ON, 6'd31, wlet_pkg::DAY_WEEKDAY, 11'd0,
			6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_ADD_OFF, 6'd0, wlet_pkg::DAY_WEEKEND, 11'd1439,
			6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_ADD_ON, 6'd5, wlet_pkg::DAY_EVERY, 11'd10, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_ADD_OFF, 6'd6, 4'd15, 11'd2047, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_TICK, 6'd0, 4'd3, 11'd0, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_TICK, 6'd0, wlet_pkg::DAY_SUN, 11'd1439, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_TICK, 6'd63, 4'd15, 11'd2047, 6'd63));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_RAND, 6'd31, wlet_pkg::DAY_WEEKDAY, 11'd0,
			6'b100010));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_TICK, 6'd0, 4'd2, 11'd1410, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_RAND, 6'd0, wlet_pkg::DAY_WEEKEND, 11'd1439,
			6'd30));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_TICK, 6'd0, wlet_pkg::DAY_SAT, 11'd29, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_TICK, 6'd0, wlet_pkg::DAY_EVERY, 11'd10, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_REMOVE, 6'd5, wlet_pkg::DAY_EVERY, 11'd11, 6'd0));
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_REMOVE, 6'd5, wlet_pkg::DAY_EVERY, 11'd10, 6'd0));
		cmd_q.push_back(pack_cmd(3'd7, 6'd63, 4'd15, 11'd2047, 6'd63));
		cmd_q.push_back(pack_cmd(CMD_NOP, 6'd0, 4'd0, 11'd0, 6'd0));
		drain();

		// fill the table past full, then tick everything at once while held off
		for (int i = 0; i < DEPTH + 2; i++)
			cmd_q.push_back(pack_cmd(wlet_pkg::CMD_ADD_ON, 6'($urandom_range(31)),
				wlet_pkg::DAY_EVERY, 11'd500, 6'd0));
		drain();
		-> hold_go;
		cmd_q.push_back(pack_cmd(wlet_pkg::CMD_TICK, 6'd0, wlet_pkg::DAY_MON, 11'd500, 6'd0));
		for (int i = 0; i < 5; i++)
			cmd_q.push_back(pack_cmd(wlet_pkg::CMD_REMOVE, 6'd40, 4'd0, 11'd0, 6'd0));
		drain();
		for (int i = 0; i < DEPTH; i++)
			cmd_q.push_back(pack_cmd(wlet_pkg::CMD_REMOVE, {1'b0, tbl_ent[i].light},
				tbl_ent[i].day, tbl_ent[i].minute, 6'd0));
		drain();

		// random phases with varied idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 88; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 88; end
				default: begin send_idle = 37; recv_stall = 37; end
			endcase
			for (int i = 0; i < 40; i++) begin
				cmd_q.push_back(rand_cmd());
				// predictor state lags the queue; wait a little so biasing sees real contents
				while (cmd_q.size() > 4) @(posedge clk);
			end
			drain();
		end

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

[files.f]
hdl/wlet_pkg.sv
hdl/wlet_cell.sv
hdl/weekly_light_event_table.sv
verif/tb_weekly_light_event_table.sv
